// ----- rtl/smsw_pkg.sv -----
// Shared types, constants and helpers for the scope marker stack walker.
// Holds the stack entry, result and stack-control types and the result codes.
// Depends on nothing; every other file in rtl/ imports it.
package smsw_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int ID_W = 30;
	localparam int KIND_W = 4;
	localparam int STAMP_W = 63;
	localparam int WORD_W = 32;
	localparam int CODE_W = 3;
	localparam int DEPTH_W = 4;
	localparam int MAX_RESULTS = 32;
	localparam int MAX_FLUSH_PAIRS = MAX_RESULTS / 2;
	localparam int PAIR_W = $clog2(MAX_FLUSH_PAIRS);

	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 4'hF;

	localparam logic [CODE_W-1:0] RC_SPAN        = 3'd0;
	localparam logic [CODE_W-1:0] RC_ORPHAN_EXIT = 3'd1;
	localparam logic [CODE_W-1:0] RC_TRANS_EMPTY = 3'd2;
	localparam logic [CODE_W-1:0] RC_UNKNOWN_ID  = 3'd3;
	localparam logic [CODE_W-1:0] RC_OPEN_AT_END = 3'd4;
	localparam logic [CODE_W-1:0] RC_OVERFLOW    = 3'd5;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [KIND_W-1:0]  kind;
		logic [STAMP_W-1:0] start;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_POP,
		OP_REPL
	} stack_op_t;

	typedef struct packed {
		stack_op_t op;
		entry_t    ent;
	} stack_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SECOND,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [CODE_W-1:0]  result_code;
		logic [STAMP_W-1:0] span_enter;
		logic [STAMP_W-1:0] span_exit;
		logic [ID_W-1:0]    span_id;
		logic [KIND_W-1:0]  span_kind;
		logic [DEPTH_W-1:0] span_depth;
		logic               point_flag;
		logic               open_flag;
		logic               last_flag;
	} result_t;

	function automatic result_t mk_res(
		input logic [CODE_W-1:0]  code,
		input logic [STAMP_W-1:0] t_in,
		input logic [STAMP_W-1:0] t_out,
		input logic [ID_W-1:0]    id,
		input logic [KIND_W-1:0]  kind,
		input logic [DEPTH_W-1:0] depth,
		input logic               point,
		input logic               open
	);
		result_t r;
		r.result_code = code;
		r.span_enter  = t_in;
		r.span_exit   = t_out;
		r.span_id     = id;
		r.span_kind   = kind;
		r.span_depth  = depth;
		r.point_flag  = point;
		r.open_flag   = open;
		r.last_flag   = 1'b0;
		return r;
	endfunction

endpackage

// ----- rtl/smsw_rec_if.sv -----
// Trace record channel: valid/ready handshake plus the record fields.
// Depends on smsw_pkg for field widths.
interface smsw_rec_if;
	import smsw_pkg::*;

	logic                valid;
	logic                ready;
	logic                req_type;
	logic [WORD_W-1:0]   marker_word;
	logic [STAMP_W-1:0]  stamp;
	logic                lookup_meta;
	logic                lookup_found;
	logic [KIND_W-1:0]   lookup_kind;

	modport source (
		output valid, req_type, marker_word, stamp, lookup_meta, lookup_found, lookup_kind,
		input  ready
	);
	modport sink (
		input  valid, req_type, marker_word, stamp, lookup_meta, lookup_found, lookup_kind,
		output ready
	);
endinterface

// ----- rtl/smsw_res_if.sv -----
// Result channel: valid/ready handshake plus the span and diagnostic fields.
// Depends on smsw_pkg for field widths.
interface smsw_res_if;
	import smsw_pkg::*;

	logic                valid;
	logic                ready;
	logic [CODE_W-1:0]   result_code;
	logic [STAMP_W-1:0]  span_enter;
	logic [STAMP_W-1:0]  span_exit;
	logic [ID_W-1:0]     span_id;
	logic [KIND_W-1:0]   span_kind;
	logic [DEPTH_W-1:0]  span_depth;
	logic                point_flag;
	logic                open_flag;
	logic                last_flag;

	modport source (
		output valid, result_code, span_enter, span_exit, span_id, span_kind, span_depth,
		       point_flag, open_flag, last_flag,
		input  ready
	);
	modport sink (
		input  valid, result_code, span_enter, span_exit, span_id, span_kind, span_depth,
		       point_flag, open_flag, last_flag,
		output ready
	);
endinterface

// ----- rtl/smsw_cell.sv -----
// One slot of the shift-register scope stack.
// Takes the entry from the slot above on push or replace and from the slot below on pop.
// Depends on smsw_pkg for entry_t and stack_ctl_t.
module smsw_cell (
	input  logic                clk,
	input  smsw_pkg::stack_ctl_t ctl,
	input  smsw_pkg::entry_t    above,
	input  smsw_pkg::entry_t    below,
	output smsw_pkg::entry_t    ent
);
	import smsw_pkg::*;

	entry_t ent_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_PUSH, OP_REPL: ent_q <= above;
			OP_POP:           ent_q <= below;
			default:          ent_q <= ent_q;
		endcase
	end

	assign ent = ent_q;
endmodule

// ----- rtl/scope_marker_stack_walker.sv -----
// Top level of the scope marker stack walker: control, chain of stack cells,
// result register. Depends on smsw_pkg, smsw_rec_if, smsw_res_if, smsw_cell.
//
//   channel | dir | modport     | carries
//   rec     | in  | smsw_rec_if | trace record or end-of-trace flush request
//   res     | out | smsw_res_if | span, open span or diagnostic code
//
// A trace record leaves zero, one or two results; the second result waits in a
// pending register and loads the output register from the second state.
// A flush gives a span and an open-at-end code per open scope (results
// for at most 16 scopes), the output register taking one result per cycle
// while not stalled; the stack pops at cell 0.
// Reset clears the control state and the scope count; cell contents are
// don't-care until pushed. A stalled output holds the result and stops intake.
module scope_marker_stack_walker #(
	parameter int STACK_DEPTH = smsw_pkg::STACK_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	smsw_rec_if.sink   rec,
	smsw_res_if.source res
);
	import smsw_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t           state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [PAIR_W-1:0] pairs_q, pairs_d;
	logic             phase_q, phase_d;
	logic             out_v_q;
	result_t          out_q;
	result_t          pend_q;

	entry_t           cell_ent [STACK_DEPTH];
	stack_ctl_t       ctl;
	entry_t           top;

	logic             free;
	logic             load;
	result_t          load_data;
	logic             pend_load;

	// record decode
	logic [ID_W-1:0]    id;
	logic               enter, exitp, found, meta, empty, full;
	logic [KIND_W-1:0]  pkind;
	logic [DEPTH_W-1:0] depth_now, depth_top, depth_inc;
	entry_t             new_ent;
	result_t            r1, r2, close_res;
	logic               r1v, r2v;
	stack_op_t          rec_op;
	logic [CW-1:0]      rec_count;
	result_t            fl_span, fl_end;
	logic               fl_last;

	assign top       = cell_ent[0];
	assign id        = rec.marker_word[WORD_W-1:2];
	assign enter     = rec.marker_word[1];
	assign exitp     = rec.marker_word[0];
	assign found     = rec.lookup_found;
	assign meta      = rec.lookup_meta | rec.lookup_found;
	assign pkind     = found ? rec.lookup_kind : KIND_UNKNOWN;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign depth_now = DEPTH_W'(count_q);
	assign depth_top = DEPTH_W'(count_q - CW'(1));
	assign depth_inc = DEPTH_W'(count_q + CW'(1));
	assign new_ent   = '{id: id, kind: pkind, start: rec.stamp};
	assign close_res = mk_res(RC_SPAN, top.start, rec.stamp, top.id, top.kind, depth_top,
		1'b0, 1'b0);

	always_comb begin
		r1        = '0;
		r2        = '0;
		r1v       = 1'b0;
		r2v       = 1'b0;
		rec_op    = OP_HOLD;
		rec_count = count_q;
		if (exitp && !enter) begin
			if (empty) begin
				if (meta) begin
					r1v = 1'b1;
					r1  = mk_res(RC_ORPHAN_EXIT, rec.stamp, rec.stamp, id, KIND_UNKNOWN,
						depth_now, 1'b0, 1'b0);
				end
			end else begin
				r1v       = 1'b1;
				r1        = close_res;
				rec_op    = OP_POP;
				rec_count = count_q - CW'(1);
			end
		end else if (exitp && enter) begin
			if (empty) begin
				if (meta) begin
					r1v       = 1'b1;
					r1        = mk_res(RC_TRANS_EMPTY, rec.stamp, rec.stamp, id, KIND_UNKNOWN,
						depth_now, 1'b0, 1'b0);
					rec_op    = OP_PUSH;
					rec_count = count_q + CW'(1);
					r2v       = !found;
					r2        = mk_res(RC_UNKNOWN_ID, rec.stamp, rec.stamp, id, KIND_UNKNOWN,
						depth_inc, 1'b0, 1'b0);
				end
			end else begin
				r1v = 1'b1;
				r1  = close_res;
				if (meta) begin
					rec_op = OP_REPL;
					r2v    = !found;
					r2     = mk_res(RC_UNKNOWN_ID, rec.stamp, rec.stamp, id, KIND_UNKNOWN,
						depth_now, 1'b0, 1'b0);
				end else begin
					rec_op    = OP_POP;
					rec_count = count_q - CW'(1);
				end
			end
		end else if (enter) begin
			if (meta) begin
				if (full) begin
					r1v = 1'b1;
					r1  = mk_res(RC_OVERFLOW, rec.stamp, rec.stamp, id, KIND_UNKNOWN,
						depth_now, 1'b0, 1'b0);
				end else begin
					rec_op    = OP_PUSH;
					rec_count = count_q + CW'(1);
					r1v       = !found;
					r1        = mk_res(RC_UNKNOWN_ID, rec.stamp, rec.stamp, id, KIND_UNKNOWN,
						depth_inc, 1'b0, 1'b0);
				end
			end
		end else begin
			if (meta) begin
				r1v = 1'b1;
				r1  = mk_res(RC_SPAN, rec.stamp, rec.stamp, id, pkind, depth_now, 1'b1, 1'b0);
				r2v = !found;
				r2  = mk_res(RC_UNKNOWN_ID, rec.stamp, rec.stamp, id, KIND_UNKNOWN,
					depth_now, 1'b0, 1'b0);
			end
		end
		r1.last_flag = !r2v;
		r2.last_flag = 1'b1;
	end

	// flush results
	assign fl_last = (count_q == CW'(1)) || (pairs_q == PAIR_W'(MAX_FLUSH_PAIRS - 1));
	always_comb begin
		fl_span = mk_res(RC_SPAN, top.start, '1, top.id, top.kind, depth_top, 1'b0, 1'b1);
		fl_end  = mk_res(RC_OPEN_AT_END, top.start, '1, top.id, top.kind, depth_top,
			1'b0, 1'b1);
		fl_end.last_flag = fl_last;
	end

	assign free = !out_v_q || res.ready;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pairs_d   = pairs_q;
		phase_d   = phase_q;
		rec.ready = 1'b0;
		load      = 1'b0;
		load_data = r1;
		pend_load = 1'b0;
		ctl.op    = OP_HOLD;
		ctl.ent   = new_ent;
		unique case (state_q)
			ST_IDLE: begin
				rec.ready = free;
				if (rec.valid && free) begin
					if (rec.req_type) begin
						if (!empty) begin
							state_d = ST_FLUSH;
							pairs_d = '0;
							phase_d = 1'b0;
						end
					end else begin
						ctl.op    = rec_op;
						count_d   = rec_count;
						load      = r1v;
						load_data = r1;
						if (r2v) begin
							pend_load = 1'b1;
							state_d   = ST_SECOND;
						end
					end
				end
			end
			ST_SECOND: begin
				if (free) begin
					load      = 1'b1;
					load_data = pend_q;
					state_d   = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (free) begin
					load = 1'b1;
					if (!phase_q) begin
						load_data = fl_span;
						phase_d   = 1'b1;
					end else begin
						load_data = fl_end;
						phase_d   = 1'b0;
						ctl.op    = OP_POP;
						count_d   = count_q - CW'(1);
						pairs_d   = pairs_q + PAIR_W'(1);
						if (fl_last) begin
							count_d = '0;
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pairs_q <= '0;
			phase_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pairs_q <= pairs_d;
			phase_q <= phase_d;
			if (load) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= load_data;
		end
		if (pend_load) begin
			pend_q <= r2;
		end
	end

	// stack cells: cell 0 is the top of stack
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		stack_ctl_t ctl_c;
		entry_t     above_c, below_c;
		if (i == 0) begin : g_top
			assign above_c = ctl.ent;
			assign ctl_c   = ctl;
		end else begin : g_mid
			assign above_c   = cell_ent[i-1];
			assign ctl_c.ent = ctl.ent;
			assign ctl_c.op  = (ctl.op == OP_REPL) ? OP_HOLD : ctl.op;
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign below_c = cell_ent[i];
		end else begin : g_inner
			assign below_c = cell_ent[i+1];
		end
		smsw_cell u_cell (
			.clk   (clk),
			.ctl   (ctl_c),
			.above (above_c),
			.below (below_c),
			.ent   (cell_ent[i])
		);
	end

	assign res.valid       = out_v_q;
	assign res.result_code = out_q.result_code;
	assign res.span_enter  = out_q.span_enter;
	assign res.span_exit   = out_q.span_exit;
	assign res.span_id     = out_q.span_id;
	assign res.span_kind   = out_q.span_kind;
	assign res.span_depth  = out_q.span_depth;
	assign res.point_flag  = out_q.point_flag;
	assign res.open_flag   = out_q.open_flag;
	assign res.last_flag   = out_q.last_flag;
endmodule
